// ===== rtl/core/sgg_pkg.sv =====
package sgg_pkg;

  localparam int COORD_W   = 16;
  localparam int SIZE_W    = COORD_W - 1;
  localparam int OUT_W     = COORD_W + 1;
  // offset from the grid origin, including border and size terms
  localparam int REL_W     = COORD_W + 2;
  localparam int MAG_W     = COORD_W + 1;
  localparam int GRID_W    = 12;
  localparam int DELTA_W   = GRID_W + 1;
  localparam int BORDER_W  = 8;
  localparam int EDGE_W    = 4;

  // remainder unit: bits retired per pipeline stage
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W       = DIV_STAGES * DIV_STEPS;
  // offset, magnitude, remainder stages, rounding step
  localparam int LANE_STAGES = DIV_STAGES + 3;
  // plus the output register
  localparam int PIPE_STAGES = LANE_STAGES + 1;

  localparam int ADDR_W     = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_IDX_GRID = '0;

  localparam logic KIND_MOVE   = 1'b0;
  localparam logic KIND_RESIZE = 1'b1;

  localparam int EDGE_TOP_BIT    = 0;
  localparam int EDGE_BOTTOM_BIT = 1;
  localparam int EDGE_LEFT_BIT   = 2;
  localparam int EDGE_RIGHT_BIT  = 3;

  typedef enum logic [1:0] {
    MODE_PASS,   // axis left as is
    MODE_MOVE,   // position snapped, size kept
    MODE_LEAD,   // leading edge snapped, trailing edge fixed
    MODE_TRAIL   // trailing edge snapped, position fixed
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic [COORD_W-1:0]  pos;
    logic [SIZE_W-1:0]   size;
  } axis_side_t;

  typedef struct packed {
    axis_side_t x;
    axis_side_t y;
  } side_t;

  typedef logic [LANE_STAGES-1:0] stage_en_t;

endpackage

// ===== rtl/core/sgg_if.sv =====
interface sgg_in_if ();
  import sgg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic [SIZE_W-1:0]          box_width;
  logic [SIZE_W-1:0]          box_height;
  logic signed [COORD_W-1:0]  origin_x;
  logic signed [COORD_W-1:0]  origin_y;
  logic [BORDER_W-1:0]        border_left;
  logic [BORDER_W-1:0]        border_top;
  logic [BORDER_W-1:0]        border_right;
  logic [BORDER_W-1:0]        border_bottom;
  logic [EDGE_W-1:0]          grab_edges;

  modport source (
    output valid, kind, pos_x, pos_y, box_width, box_height, origin_x, origin_y,
           border_left, border_top, border_right, border_bottom, grab_edges,
    input  ready
  );

  modport sink (
    input  valid, kind, pos_x, pos_y, box_width, box_height, origin_x, origin_y,
           border_left, border_top, border_right, border_bottom, grab_edges,
    output ready
  );
endinterface

interface sgg_out_if ();
  import sgg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  out_x;
  logic signed [OUT_W-1:0]  out_y;
  logic signed [OUT_W-1:0]  out_width;
  logic signed [OUT_W-1:0]  out_height;

  modport source (
    output valid, out_x, out_y, out_width, out_height,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_width, out_height,
    output ready
  );
endinterface

// ===== rtl/core/snap_geometry_to_grid_top.sv =====
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   kind, pos_x/y, box_width/height, origin_x/y,
//                              border_left/top/right/bottom, grab_edges
// out_o     out  valid/ready   out_x, out_y, out_width, out_height
// apb       in   psel/penable  grid_size at byte address 0 (paddr[2] == 0)
//
// One item per cycle while out_o is not stalled; the pipeline stages are:
// offset, magnitude, DIV_STAGES remainder stages of DIV_STEPS bits each,
// rounding, output register. The remainder pipeline in each axis lane sets
// the depth. Every stage holds its own valid bit, so bubbles close up and a
// new item is taken while a finished result waits at the output.
// rst_ni clears grid_size (snapping off) and all valid bits; no clearing pass.
module snap_geometry_to_grid_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sgg_in_if.sink                           in_i,
  sgg_out_if.source                        out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sgg_pkg::ADDR_W-1:0]       paddr,
  input  logic [sgg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sgg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import sgg_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration: grid pitch. The user must write it only while the pipeline
  // is empty (the block leaves this unchecked), so the lanes read it directly.
  // ---------------------------------------------------------------------
  logic [GRID_W-1:0] grid_q;
  logic              grid_we;

  assign pready  = 1'b1;
  assign grid_we = psel && penable && pwrite && pready &&
                   (paddr[ADDR_W-1:2] == REG_IDX_GRID);
  assign prdata  = (paddr[ADDR_W-1:2] == REG_IDX_GRID) ? APB_DATA_W'(grid_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= '0;
    end else if (grid_we) begin
      grid_q <= pwdata[GRID_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Per-axis decode. Every case reduces to one correction per axis: the
  // value snapped is either the border-adjusted leading edge or the
  // border-adjusted trailing edge, and the result is that edge's offset
  // to the nearest grid line applied to position or size.
  // ---------------------------------------------------------------------
  function automatic mode_e axis_mode(input logic en, input logic kind,
                                      input logic lead, input logic trail);
    mode_e m;
    if (!en) begin
      m = MODE_PASS;
    end else if (kind == KIND_MOVE) begin
      m = MODE_MOVE;
    end else if (lead) begin
      m = MODE_LEAD;          // top wins over bottom, left over right
    end else if (trail) begin
      m = MODE_TRAIL;
    end else begin
      m = MODE_PASS;
    end
    return m;
  endfunction

  function automatic logic signed [REL_W-1:0] axis_rel(
    input mode_e               m,
    input logic [COORD_W-1:0]  pos,
    input logic [SIZE_W-1:0]   size,
    input logic [BORDER_W-1:0] b_lead,
    input logic [BORDER_W-1:0] b_trail,
    input logic [COORD_W-1:0]  org
  );
    logic signed [REL_W-1:0] p, o, s, bl, bt;
    p  = $signed({{(REL_W-COORD_W){pos[COORD_W-1]}}, pos});
    o  = $signed({{(REL_W-COORD_W){org[COORD_W-1]}}, org});
    s  = $signed({{(REL_W-SIZE_W){1'b0}}, size});
    bl = $signed({{(REL_W-BORDER_W){1'b0}}, b_lead});
    bt = $signed({{(REL_W-BORDER_W){1'b0}}, b_trail});
    if (m == MODE_TRAIL) begin
      axis_rel = p + s + bt - o;
    end else begin
      axis_rel = p - bl - o;
    end
  endfunction

  logic                    snap_en;
  side_t                   side_in;
  logic signed [REL_W-1:0] rel_x, rel_y;

  assign snap_en = (grid_q > GRID_W'(1));

  always_comb begin
    side_in.x.mode = axis_mode(snap_en, in_i.kind,
                               in_i.grab_edges[EDGE_LEFT_BIT],
                               in_i.grab_edges[EDGE_RIGHT_BIT]);
    side_in.x.pos  = in_i.pos_x;
    side_in.x.size = in_i.box_width;
    side_in.y.mode = axis_mode(snap_en, in_i.kind,
                               in_i.grab_edges[EDGE_TOP_BIT],
                               in_i.grab_edges[EDGE_BOTTOM_BIT]);
    side_in.y.pos  = in_i.pos_y;
    side_in.y.size = in_i.box_height;
    rel_x = axis_rel(side_in.x.mode, in_i.pos_x, in_i.box_width,
                     in_i.border_left, in_i.border_right, in_i.origin_x);
    rel_y = axis_rel(side_in.y.mode, in_i.pos_y, in_i.box_height,
                     in_i.border_top, in_i.border_bottom, in_i.origin_y);
  end

  // ---------------------------------------------------------------------
  // Pipeline control: a stage can take data when it is empty or its
  // contents move on this cycle.
  // ---------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] vld_q, vld_d, free, ld;

  always_comb begin
    free[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || out_o.ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      free[k] = !vld_q[k] || free[k+1];
    end
    ld[0]    = in_i.valid && free[0];
    vld_d[0] = free[0] ? in_i.valid : vld_q[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      ld[k]    = vld_q[k-1] && free[k];
      vld_d[k] = free[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = free[0];
  assign out_o.valid = vld_q[PIPE_STAGES-1];

  // geometry that rides alongside the lanes
  side_t side_q [LANE_STAGES];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      side_q[0] <= side_in;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (ld[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Lanes: one per axis
  // ---------------------------------------------------------------------
  stage_en_t                 lane_ld;
  logic signed [DELTA_W-1:0] delta_x, delta_y;

  assign lane_ld = ld[LANE_STAGES-1:0];

  sgg_lane u_lane_x (
    .clk_i   (clk_i),
    .ld_i    (lane_ld),
    .pitch_i (grid_q),
    .rel_i   (rel_x),
    .delta_o (delta_x)
  );

  sgg_lane u_lane_y (
    .clk_i   (clk_i),
    .ld_i    (lane_ld),
    .pitch_i (grid_q),
    .rel_i   (rel_y),
    .delta_o (delta_y)
  );

  sgg_merge u_merge (
    .clk_i        (clk_i),
    .ld_i         (ld[PIPE_STAGES-1]),
    .side_i       (side_q[LANE_STAGES-1]),
    .delta_x_i    (delta_x),
    .delta_y_i    (delta_y),
    .out_x_o      (out_o.out_x),
    .out_y_o      (out_o.out_y),
    .out_width_o  (out_o.out_width),
    .out_height_o (out_o.out_height)
  );

endmodule

// ===== rtl/core/sgg_lane.sv =====
// One axis: floor remainder of the offset by the pitch, then the signed
// correction that moves the value to the nearest grid line.
module sgg_lane (
  input  logic                               clk_i,
  input  sgg_pkg::stage_en_t                 ld_i,
  input  logic [sgg_pkg::GRID_W-1:0]         pitch_i,
  input  logic signed [sgg_pkg::REL_W-1:0]   rel_i,
  output logic signed [sgg_pkg::DELTA_W-1:0] delta_o
);
  import sgg_pkg::*;

  logic signed [REL_W-1:0] rel_q;
  logic [REL_W-1:0]        abs_rel;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q;

  logic [GRID_W-1:0] rem_q   [DIV_STAGES];
  logic [DIV_W-1:0]  dmag_q  [DIV_STAGES];
  logic              dneg_q  [DIV_STAGES];
  logic [GRID_W-1:0] rem_in  [DIV_STAGES];
  logic [DIV_W-1:0]  dmag_in [DIV_STAGES];
  logic              dneg_in [DIV_STAGES];
  logic [GRID_W-1:0] rem_nxt [DIV_STAGES];

  logic [GRID_W-1:0]         fmod;
  logic [GRID_W:0]           twice;
  logic signed [DELTA_W-1:0] delta_d;
  logic signed [DELTA_W-1:0] delta_q;

  assign abs_rel = rel_q[REL_W-1] ? (~$unsigned(rel_q) + 1'b1) : $unsigned(rel_q);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      rel_q <= rel_i;
    end
    if (ld_i[1]) begin
      mag_q <= abs_rel[MAG_W-1:0];
      neg_q <= rel_q[REL_W-1];
    end
  end

  always_comb begin
    rem_in[0]  = '0;
    dmag_in[0] = DIV_W'(mag_q);
    dneg_in[0] = neg_q;
    for (int j = 1; j < DIV_STAGES; j++) begin
      rem_in[j]  = rem_q[j-1];
      dmag_in[j] = dmag_q[j-1];
      dneg_in[j] = dneg_q[j-1];
    end
  end

  // restoring remainder, MSB first, DIV_STEPS bits per stage
  always_comb begin
    logic [GRID_W:0] t;
    t = '0;
    for (int j = 0; j < DIV_STAGES; j++) begin
      rem_nxt[j] = rem_in[j];
      for (int i = 0; i < DIV_STEPS; i++) begin
        t = {rem_nxt[j], dmag_in[j][DIV_W-1-(j*DIV_STEPS+i)]};
        if (t >= {1'b0, pitch_i}) begin
          t = t - {1'b0, pitch_i};
        end
        rem_nxt[j] = t[GRID_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (ld_i[2+j]) begin
        rem_q[j]  <= rem_nxt[j];
        dmag_q[j] <= dmag_in[j];
        dneg_q[j] <= dneg_in[j];
      end
    end
  end

  // floor modulo for negative offsets, then round half up
  always_comb begin
    if (dneg_q[DIV_STAGES-1] && (rem_q[DIV_STAGES-1] != '0)) begin
      fmod = pitch_i - rem_q[DIV_STAGES-1];
    end else begin
      fmod = rem_q[DIV_STAGES-1];
    end
    twice = {fmod, 1'b0};
    if (twice >= {1'b0, pitch_i}) begin
      delta_d = $signed({1'b0, pitch_i - fmod});
    end else begin
      delta_d = -$signed({1'b0, fmod});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[LANE_STAGES-1]) begin
      delta_q <= delta_d;
    end
  end

  assign delta_o = delta_q;

endmodule

// ===== rtl/core/sgg_merge.sv =====
// Combines the lane corrections with the carried geometry into the result.
module sgg_merge (
  input  logic                               clk_i,
  input  logic                               ld_i,
  input  sgg_pkg::side_t                     side_i,
  input  logic signed [sgg_pkg::DELTA_W-1:0] delta_x_i,
  input  logic signed [sgg_pkg::DELTA_W-1:0] delta_y_i,
  output logic signed [sgg_pkg::OUT_W-1:0]   out_x_o,
  output logic signed [sgg_pkg::OUT_W-1:0]   out_y_o,
  output logic signed [sgg_pkg::OUT_W-1:0]   out_width_o,
  output logic signed [sgg_pkg::OUT_W-1:0]   out_height_o
);
  import sgg_pkg::*;

  logic signed [OUT_W-1:0] x_d, y_d, w_d, h_d;
  logic signed [OUT_W-1:0] x_q, y_q, w_q, h_q;

  function automatic logic signed [OUT_W-1:0] ext_delta(input logic [DELTA_W-1:0] d);
    ext_delta = $signed({{(OUT_W-DELTA_W){d[DELTA_W-1]}}, d});
  endfunction

  function automatic logic signed [OUT_W-1:0] axis_pos(input axis_side_t a,
                                                       input logic [DELTA_W-1:0] d);
    logic signed [OUT_W-1:0] p;
    p = $signed({{(OUT_W-COORD_W){a.pos[COORD_W-1]}}, a.pos});
    case (a.mode)
      MODE_MOVE, MODE_LEAD: axis_pos = p + ext_delta(d);
      default:              axis_pos = p;
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] axis_size(input axis_side_t a,
                                                        input logic [DELTA_W-1:0] d);
    logic signed [OUT_W-1:0] s;
    s = $signed({{(OUT_W-SIZE_W){1'b0}}, a.size});
    case (a.mode)
      MODE_LEAD:  axis_size = s - ext_delta(d);
      MODE_TRAIL: axis_size = s + ext_delta(d);
      default:    axis_size = s;
    endcase
  endfunction

  always_comb begin
    x_d = axis_pos(side_i.x, delta_x_i);
    w_d = axis_size(side_i.x, delta_x_i);
    y_d = axis_pos(side_i.y, delta_y_i);
    h_d = axis_size(side_i.y, delta_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      x_q <= x_d;
      y_q <= y_d;
      w_q <= w_d;
      h_q <= h_d;
    end
  end

  assign out_x_o      = x_q;
  assign out_y_o      = y_q;
  assign out_width_o  = w_q;
  assign out_height_o = h_q;

endmodule

// ===== rtl/core/sgg_checker.sv =====
module sgg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [sgg_pkg::OUT_W-1:0]       out_x_i,
  input logic [sgg_pkg::OUT_W-1:0]       out_y_i,
  input logic [sgg_pkg::OUT_W-1:0]       out_width_i,
  input logic [sgg_pkg::OUT_W-1:0]       out_height_i
);
  import sgg_pkg::*;

  localparam int CNT_W = $clog2(PIPE_STAGES + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) &&
    $stable(out_y_i) && $stable(out_width_i) && $stable(out_height_i))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without an outstanding item");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_STAGES))
    else $error("more items in flight than pipeline stages");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cnt_q == '0 |-> ##(PIPE_STAGES) out_valid_i)
    else $error("item into an empty pipeline did not arrive on time");

endmodule

bind snap_geometry_to_grid_top sgg_checker u_sgg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_x_i      (out_o.out_x),
  .out_y_i      (out_o.out_y),
  .out_width_i  (out_o.out_width),
  .out_height_i (out_o.out_height)
);
